/* design/rpsp_pkg.sv */
// ----------------------------------------------------------------------------
// rpsp_pkg
// Shared types and character codes for the relative path segment parser.
// ----------------------------------------------------------------------------
package rpsp_pkg;

   // Path-data characters that steer the parser
   localparam logic [7:0] CHAR_CLOSE = 8'h7A;  // 'z'
   localparam logic [7:0] CHAR_LINE  = 8'h6C;  // 'l'
   localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
   localparam logic [7:0] CHAR_POINT = 8'h2E;  // '.'
   localparam logic [7:0] CHAR_COMMA = 8'h2C;  // ','
   localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'

   // Decimal radix of the coordinate digits
   localparam int unsigned RADIX = 10;

   // Parser phase, one-hot
   typedef enum logic [6:0] {
      PH_IDLE   = 7'b000_0001,
      PH_XSTART = 7'b000_0010,
      PH_XINT   = 7'b000_0100,
      PH_XFRAC  = 7'b000_1000,
      PH_YSTART = 7'b001_0000,
      PH_YINT   = 7'b010_0000,
      PH_YFRAC  = 7'b100_0000
   } phase_type;

endpackage

/* design/rpsp_if.sv */
// ----------------------------------------------------------------------------
// rpsp_req_if / rpsp_rsp_if
// Valid/ready channels: path characters in, line segments out.
// ----------------------------------------------------------------------------
interface rpsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       path_start;

   modport source (output valid, output char_code, output path_start, input ready);
   modport sink   (input valid, input char_code, input path_start, output ready);
endinterface

interface rpsp_rsp_if #(
   parameter int COORD_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] from_x;
   logic signed [COORD_WIDTH-1:0] from_y;
   logic signed [COORD_WIDTH-1:0] to_x;
   logic signed [COORD_WIDTH-1:0] to_y;
   logic                          last;

   modport source (output valid, output from_x, output from_y, output to_x, output to_y,
                   output last, input ready);
   modport sink   (input valid, input from_x, input from_y, input to_x, input to_y,
                   input last, output ready);
endinterface

/* design/relative_path_segment_parser.sv */
// ----------------------------------------------------------------------------
// relative_path_segment_parser
// Turns relative path-data characters into line segments.
// ----------------------------------------------------------------------------
// One character is taken per clock while the skid entry is empty. Its whole
// effect (digit accumulation, sign handling, pen update with saturation) is
// worked out in the cycle it is accepted and the segment, if any, lands on the
// next edge in the output register, or in the skid entry if the output
// register still holds a segment that is not taken. A two-entry output buffer
// (output register plus skid) lets input keep flowing while a segment waits;
// input stalls only when both entries are full. Sustained rate is one character
// per cycle while the skid entry stays empty, set by the parser state update.
module relative_path_segment_parser
   import rpsp_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   rpsp_req_if.sink      req_bus,
   rpsp_rsp_if.source    rsp_bus
);

   localparam int W  = COORD_WIDTH;
   localparam int AW = W + 1;   // accumulator, holds +2^(W-1)
   localparam int MW = W + 6;   // accumulator times radix plus digit
   localparam int TW = W + 2;   // signed magnitude after negation
   localparam int SW = W + 1;   // pen sum

   localparam logic signed [MW-1:0] ACC_HI = MW'(64'd1 << (W - 1));
   localparam logic signed [MW-1:0] ACC_LO = -ACC_HI;
   localparam logic signed [TW-1:0] VMAX_T = TW'((64'd1 << (W - 1)) - 64'd1);
   localparam logic signed [TW-1:0] VMIN_T = -VMAX_T - TW'(1);
   localparam logic signed [SW-1:0] VMAX_S = SW'((64'd1 << (W - 1)) - 64'd1);
   localparam logic signed [SW-1:0] VMIN_S = -VMAX_S - SW'(1);

   typedef struct packed {
      logic signed [W-1:0] from_x;
      logic signed [W-1:0] from_y;
      logic signed [W-1:0] to_x;
      logic signed [W-1:0] to_y;
      logic                last;
   } seg_type;

   // Parser state
   phase_type            phase_ff, phase_in;
   logic                 minus_ff, minus_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [W-1:0]  held_dx_ff, held_dx_in;
   logic signed [W-1:0]  pen_x_ff, pen_x_in;
   logic signed [W-1:0]  pen_y_ff, pen_y_in;
   logic signed [W-1:0]  start_x_ff, start_x_in;
   logic signed [W-1:0]  start_y_ff, start_y_in;
   logic                 have_start_ff, have_start_in;

   // Output buffer
   logic    out_valid_ff, out_valid_in;
   seg_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   seg_type skid_data_ff, skid_data_in;

   logic                 accept;
   logic                 pop;
   logic                 push;
   logic                 pair_end;
   seg_type              push_data;
   logic [7:0]           ch;
   logic                 at_start;
   logic signed [AW-1:0] base_acc;
   logic                 base_minus;
   logic signed [MW-1:0] digit_val;
   logic signed [MW-1:0] acc_ext;
   logic signed [MW-1:0] acc_prod;
   logic signed [AW-1:0] acc_sum;
   logic signed [TW-1:0] tv_ext;
   logic signed [TW-1:0] tv_signed;
   logic signed [W-1:0]  taken;
   logic signed [SW-1:0] px_raw;
   logic signed [SW-1:0] py_raw;
   logic signed [W-1:0]  px_sum;
   logic signed [W-1:0]  py_sum;

   assign ch     = req_bus.char_code;
   assign accept = req_bus.valid && req_bus.ready;
   assign pop    = out_valid_ff && rsp_bus.ready;

   // A start phase behaves as if the number were freshly cleared
   assign at_start   = (phase_ff == PH_XSTART) || (phase_ff == PH_YSTART);
   assign base_acc   = at_start ? '0 : acc_ff;
   assign base_minus = at_start ? 1'b0 : minus_ff;

   // Digit accumulation: acc * 10 + (code - '0'), saturated
   assign digit_val = $signed(MW'(ch)) - $signed(MW'(CHAR_ZERO));
   assign acc_ext   = MW'(base_acc);
   assign acc_prod  = acc_ext * $signed(MW'(RADIX)) + digit_val;
   always_comb begin
      if (acc_prod > ACC_HI) begin
         acc_sum = ACC_HI[AW-1:0];
      end else if (acc_prod < ACC_LO) begin
         acc_sum = ACC_LO[AW-1:0];
      end else begin
         acc_sum = acc_prod[AW-1:0];
      end
   end

   // Signed value of the finished number, saturated to the coordinate range
   assign tv_ext    = TW'(base_acc);
   assign tv_signed = base_minus ? -tv_ext : tv_ext;
   always_comb begin
      if (tv_signed > VMAX_T) begin
         taken = VMAX_T[W-1:0];
      end else if (tv_signed < VMIN_T) begin
         taken = VMIN_T[W-1:0];
      end else begin
         taken = tv_signed[W-1:0];
      end
   end

   // Relative pen move, saturated
   assign px_raw = SW'(pen_x_ff) + SW'(held_dx_ff);
   assign py_raw = SW'(pen_y_ff) + SW'(taken);
   always_comb begin
      if (px_raw > VMAX_S) begin
         px_sum = VMAX_S[W-1:0];
      end else if (px_raw < VMIN_S) begin
         px_sum = VMIN_S[W-1:0];
      end else begin
         px_sum = px_raw[W-1:0];
      end
      if (py_raw > VMAX_S) begin
         py_sum = VMAX_S[W-1:0];
      end else if (py_raw < VMIN_S) begin
         py_sum = VMIN_S[W-1:0];
      end else begin
         py_sum = py_raw[W-1:0];
      end
   end

   // Parser next state
   always_comb begin
      phase_in      = phase_ff;
      minus_in      = minus_ff;
      acc_in        = acc_ff;
      held_dx_in    = held_dx_ff;
      pen_x_in      = pen_x_ff;
      pen_y_in      = pen_y_ff;
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      have_start_in = have_start_ff;
      pair_end      = 1'b0;
      push          = 1'b0;
      push_data     = '{from_x: pen_x_ff, from_y: pen_y_ff,
                        to_x: px_sum, to_y: py_sum, last: 1'b0};

      if (accept) begin
         if (req_bus.path_start) begin
            phase_in      = PH_XSTART;
            minus_in      = 1'b0;
            acc_in        = '0;
            held_dx_in    = '0;
            pen_x_in      = '0;
            pen_y_in      = '0;
            start_x_in    = '0;
            start_y_in    = '0;
            have_start_in = 1'b0;
         end else begin
            unique case (phase_ff) inside
               PH_IDLE: begin
               end
               PH_XSTART, PH_XINT: begin
                  if ((phase_ff == PH_XSTART) && (ch == CHAR_CLOSE)) begin
                     phase_in = PH_IDLE;
                     minus_in = 1'b0;
                     acc_in   = '0;
                  end else if ((phase_ff == PH_XSTART) && (ch == CHAR_MINUS)) begin
                     phase_in = PH_XINT;
                     minus_in = 1'b1;
                     acc_in   = '0;
                  end else begin
                     minus_in = base_minus;
                     if (ch == CHAR_POINT) begin
                        phase_in = PH_XFRAC;
                        acc_in   = base_acc;
                     end else if (ch == CHAR_COMMA) begin
                        phase_in   = PH_YSTART;
                        held_dx_in = taken;
                        minus_in   = 1'b0;
                        acc_in     = '0;
                     end else begin
                        phase_in = PH_XINT;
                        acc_in   = acc_sum;
                     end
                  end
               end
               PH_XFRAC: begin
                  if (ch == CHAR_COMMA) begin
                     phase_in   = PH_YSTART;
                     held_dx_in = taken;
                     minus_in   = 1'b0;
                     acc_in     = '0;
                  end
               end
               PH_YSTART, PH_YINT: begin
                  if ((phase_ff == PH_YSTART) && (ch == CHAR_MINUS)) begin
                     phase_in = PH_YINT;
                     minus_in = 1'b1;
                     acc_in   = '0;
                  end else begin
                     minus_in = base_minus;
                     if (ch == CHAR_POINT) begin
                        phase_in = PH_YFRAC;
                        acc_in   = base_acc;
                     end else if ((ch == CHAR_LINE) || (ch == CHAR_CLOSE)) begin
                        pair_end = 1'b1;
                     end else begin
                        phase_in = PH_YINT;
                        acc_in   = acc_sum;
                     end
                  end
               end
               PH_YFRAC: begin
                  if ((ch == CHAR_LINE) || (ch == CHAR_CLOSE)) begin
                     pair_end = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase

            // End of a coordinate pair
            if (pair_end) begin
               minus_in   = 1'b0;
               acc_in     = '0;
               held_dx_in = '0;
               if (!have_start_ff) begin
                  // first pair only places the start point
                  pen_x_in      = px_sum;
                  pen_y_in      = py_sum;
                  start_x_in    = px_sum;
                  start_y_in    = py_sum;
                  have_start_in = 1'b1;
                  phase_in      = (ch == CHAR_CLOSE) ? PH_IDLE : PH_XSTART;
               end else if (ch == CHAR_CLOSE) begin
                  // closing segment back to start, displacement dropped
                  push      = 1'b1;
                  push_data = '{from_x: pen_x_ff, from_y: pen_y_ff,
                                to_x: start_x_ff, to_y: start_y_ff, last: 1'b1};
                  phase_in  = PH_IDLE;
               end else begin
                  push     = 1'b1;
                  pen_x_in = px_sum;
                  pen_y_in = py_sum;
                  phase_in = PH_XSTART;
               end
            end
         end
      end
   end

   // Output buffer: output register with a skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         minus_ff      <= 1'b0;
         acc_ff        <= '0;
         held_dx_ff    <= '0;
         pen_x_ff      <= '0;
         pen_y_ff      <= '0;
         start_x_ff    <= '0;
         start_y_ff    <= '0;
         have_start_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         minus_ff      <= minus_in;
         acc_ff        <= acc_in;
         held_dx_ff    <= held_dx_in;
         pen_x_ff      <= pen_x_in;
         pen_y_ff      <= pen_y_in;
         start_x_ff    <= start_x_in;
         start_y_ff    <= start_y_in;
         have_start_ff <= have_start_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Segment payload, no reset needed
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_bus.ready  = !skid_valid_ff;
   assign rsp_bus.valid  = out_valid_ff;
   assign rsp_bus.from_x = out_data_ff.from_x;
   assign rsp_bus.from_y = out_data_ff.from_y;
   assign rsp_bus.to_x   = out_data_ff.to_x;
   assign rsp_bus.to_y   = out_data_ff.to_y;
   assign rsp_bus.last   = out_data_ff.last;

endmodule

/* dv/relative_path_segment_parser_tb.sv */
// ----------------------------------------------------------------------------
// relative_path_segment_parser_tb
// Self-checking bench for the relative path segment parser. Path characters
// go in through the request channel; every segment taken from the response
// channel is checked field by field against a cycle-free parser held in a
// small scoreboard class. A short directed run of paths is followed by
// random paths with random content, restarts and noise bytes, under random
// gaps and response back-pressure.
// ----------------------------------------------------------------------------
module relative_path_segment_parser_tb
   import rpsp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_WIDTH   = 16;
   localparam int COORD_MAX     = (1 << (COORD_WIDTH - 1)) - 1;
   localparam int COORD_MIN     = -COORD_MAX - 1;
   localparam int RANDOM_CHARS  = 700;
   localparam int LONG_HOLD     = 150;
   localparam int DRAIN_LIMIT   = 5000;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct {
      coord_type from_x;
      coord_type from_y;
      coord_type to_x;
      coord_type to_y;
      logic      last;
   } segment_type;

   // -------------------------------------------------------------------------
   // Scoreboard: parses accepted characters and holds the segments they imply
   // -------------------------------------------------------------------------
   class segment_tracker_type;
      phase_type   phase;
      bit          minus_seen;
      int          number_acc;
      coord_type   held_dx;
      coord_type   pen_x, pen_y;
      coord_type   start_x, start_y;
      bit          have_start;
      segment_type pending_segments[$];
      int          errors;
      int          chars_taken;
      int          paths_started;
      int          segments_checked;
      int          closes_checked;

      function new();
         clear_path();
         phase = PH_IDLE;
      endfunction

      function void clear_path();
         minus_seen = 1'b0;
         number_acc = 0;
         held_dx    = '0;
         pen_x      = '0;
         pen_y      = '0;
         start_x    = '0;
         start_y    = '0;
         have_start = 1'b0;
      endfunction

      function int clip(int v, int lo, int hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      // any non-terminator in the integer part counts as a digit
      function void add_digit(logic [7:0] c);
         number_acc = clip(number_acc * int'(RADIX) + (int'(c) - int'(CHAR_ZERO)),
                           COORD_MIN, COORD_MAX + 1);
      endfunction

      function coord_type take_value();
         int v;
         v = minus_seen ? -number_acc : number_acc;
         minus_seen = 1'b0;
         number_acc = 0;
         return coord_type'(clip(v, COORD_MIN, COORD_MAX));
      endfunction

      // pair finished by 'l' or 'z'
      function void end_pair(logic [7:0] c);
         coord_type   dx, dy;
         segment_type seg;
         dy = take_value();
         dx = held_dx;
         held_dx = '0;
         if (!have_start) begin
            // first pair only places the start point
            pen_x      = coord_type'(clip(int'(pen_x) + int'(dx), COORD_MIN, COORD_MAX));
            pen_y      = coord_type'(clip(int'(pen_y) + int'(dy), COORD_MIN, COORD_MAX));
            start_x    = pen_x;
            start_y    = pen_y;
            have_start = 1'b1;
            phase      = (c == CHAR_CLOSE) ? PH_IDLE : PH_XSTART;
         end else if (c == CHAR_CLOSE) begin
            // closing segment ignores the pair's displacement
            seg = '{pen_x, pen_y, start_x, start_y, 1'b1};
            pending_segments.push_back(seg);
            phase = PH_IDLE;
         end else begin
            seg.from_x = pen_x;
            seg.from_y = pen_y;
            pen_x      = coord_type'(clip(int'(pen_x) + int'(dx), COORD_MIN, COORD_MAX));
            pen_y      = coord_type'(clip(int'(pen_y) + int'(dy), COORD_MIN, COORD_MAX));
            seg.to_x   = pen_x;
            seg.to_y   = pen_y;
            seg.last   = 1'b0;
            pending_segments.push_back(seg);
            phase = PH_XSTART;
         end
      endfunction

      function void x_int_char(logic [7:0] c);
         if (c == CHAR_POINT) begin
            phase = PH_XFRAC;
         end else if (c == CHAR_COMMA) begin
            held_dx = take_value();
            phase   = PH_YSTART;
         end else begin
            add_digit(c);
         end
      endfunction

      function void y_int_char(logic [7:0] c);
         if (c == CHAR_POINT) begin
            phase = PH_YFRAC;
         end else if (c == CHAR_LINE || c == CHAR_CLOSE) begin
            end_pair(c);
         end else begin
            add_digit(c);
         end
      endfunction

      // one accepted item on the request channel
      function void take_char(logic [7:0] c, logic s);
         chars_taken++;
         if (s) begin
            clear_path();
            paths_started++;
            phase = PH_XSTART;
            return;
         end
         case (phase)
            PH_XSTART: begin
               minus_seen = 1'b0;
               number_acc = 0;
               if (c == CHAR_CLOSE) begin
                  phase = PH_IDLE;
               end else if (c == CHAR_MINUS) begin
                  minus_seen = 1'b1;
                  phase      = PH_XINT;
               end else begin
                  phase = PH_XINT;
                  x_int_char(c);
               end
            end
            PH_XINT: x_int_char(c);
            PH_XFRAC: begin
               if (c == CHAR_COMMA) begin
                  held_dx = take_value();
                  phase   = PH_YSTART;
               end
            end
            PH_YSTART: begin
               minus_seen = 1'b0;
               number_acc = 0;
               if (c == CHAR_MINUS) begin
                  minus_seen = 1'b1;
                  phase      = PH_YINT;
               end else begin
                  phase = PH_YINT;
                  y_int_char(c);
               end
            end
            PH_YINT: y_int_char(c);
            PH_YFRAC: begin
               if (c == CHAR_LINE || c == CHAR_CLOSE) end_pair(c);
            end
            default: ;
         endcase
      endfunction

      // one accepted item on the response channel
      function void check_segment(coord_type fx, coord_type fy, coord_type tx,
                                  coord_type ty, logic lst);
         segment_type exp_seg;
         if (pending_segments.size() == 0) begin
            $error("unexpected segment (%0d,%0d)->(%0d,%0d) last=%0b",
                   fx, fy, tx, ty, lst);
            errors++;
            return;
         end
         exp_seg = pending_segments.pop_front();
         segments_checked++;
         if (lst) closes_checked++;
         if (fx !== exp_seg.from_x) begin
            $error("from_x: expected %0d, got %0d", exp_seg.from_x, fx);
            errors++;
         end
         if (fy !== exp_seg.from_y) begin
            $error("from_y: expected %0d, got %0d", exp_seg.from_y, fy);
            errors++;
         end
         if (tx !== exp_seg.to_x) begin
            $error("to_x: expected %0d, got %0d", exp_seg.to_x, tx);
            errors++;
         end
         if (ty !== exp_seg.to_y) begin
            $error("to_y: expected %0d, got %0d", exp_seg.to_y, ty);
            errors++;
         end
         if (lst !== exp_seg.last) begin
            $error("last: expected %0b, got %0b", exp_seg.last, lst);
            errors++;
         end
      endfunction

      function int close_out();
         if (pending_segments.size() != 0) begin
            $error("%0d expected segments never arrived", pending_segments.size());
            errors++;
         end
         return errors;
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;           // no random gaps on either side while set
   int   random_sent;

   segment_tracker_type tracker = new();

   rpsp_req_if                                req_bus ();
   rpsp_rsp_if #(.COORD_WIDTH(COORD_WIDTH))   rsp_bus ();

   relative_path_segment_parser #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Gap length: mostly none, some short, a few long
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // -------------------------------------------------------------------------
   // Request side: called at a falling edge, returns at a falling edge
   // -------------------------------------------------------------------------
   task automatic send_char(input logic [7:0] c, input logic s);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.char_code  <= c;
      req_bus.path_start <= s;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      tracker.take_char(c, s);
      random_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string txt, input logic start_first);
      foreach (txt[i]) send_char(txt[i], start_first && (i == 0));
   endtask

   // a byte with no special meaning inside a number
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom);
      while (b == CHAR_COMMA || b == CHAR_POINT || b == CHAR_MINUS ||
             b == CHAR_LINE || b == CHAR_CLOSE);
      return b;
   endfunction

   // one coordinate: optional sign, digits, optional ignored fraction
   task automatic send_number(input bit is_y);
      int         ndig;
      int         nfrac;
      logic [7:0] b;
      if ($urandom_range(0, 9) < 3) send_char(CHAR_MINUS, 1'b0);
      ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
      repeat (ndig) begin
         if ($urandom_range(0, 99) < 94) send_char(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
         else send_char(plain_byte(), 1'b0);
      end
      if ($urandom_range(0, 4) == 0) begin
         send_char(CHAR_POINT, 1'b0);
         nfrac = $urandom_range(0, 3);
         repeat (nfrac) begin
            do b = 8'($urandom);
            while (is_y ? (b == CHAR_LINE || b == CHAR_CLOSE) : (b == CHAR_COMMA));
            send_char(b, 1'b0);
         end
      end
   endtask

   // one random path, sometimes cut short or left open
   task automatic send_path();
      int npairs;
      npairs = $urandom_range(1, 6);
      send_char(8'($urandom), 1'b1);
      for (int p = 0; p < npairs; p++) begin
         // occasional break: restart in the middle of a pair
         if ($urandom_range(0, 29) == 0) begin
            send_number(1'b0);
            return;
         end
         send_number(1'b0);
         send_char(CHAR_COMMA, 1'b0);
         send_number(1'b1);
         if (p == npairs - 1 && $urandom_range(0, 4) != 0) send_char(CHAR_CLOSE, 1'b0);
         else send_char(CHAR_LINE, 1'b0);
      end
      // leading close where a pair would begin
      if ($urandom_range(0, 9) == 0) send_char(CHAR_CLOSE, 1'b0);
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 5);
      repeat (n) send_char(8'($urandom), ($urandom_range(0, 9) == 0));
   endtask

   // -------------------------------------------------------------------------
   // Response side: ready with random stalls and one long hold-off
   // -------------------------------------------------------------------------
   initial begin
      int stall_left;
      bit held_long;
      stall_left = 0;
      held_long  = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_long && tracker.segments_checked >= 20) begin
            held_long  = 1'b1;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = draw_gap();
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         tracker.check_segment(rsp_bus.from_x, rsp_bus.from_y, rsp_bus.to_x,
                               rsp_bus.to_y, rsp_bus.last);
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int waited;
      req_bus.valid      = 1'b0;
      req_bus.char_code  = '0;
      req_bus.path_start = 1'b0;
      steady = 1'b0;
      reset  = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle byte, fractions, saturation, odd digits, restarts
      send_char(CHAR_ZERO + 8'd7, 1'b0);
      send_text("M1.5,2l", 1'b1);
      send_text("99999,-8l", 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(8'h00, 1'b0);
      send_text(",1z", 1'b0);
      send_text("Mz", 1'b1);
      send_text("M6,", 1'b1);
      send_text("M4,4z", 1'b1);

      // random paths with some noise between them
      random_sent = 0;
      while (random_sent < RANDOM_CHARS) begin
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) send_noise();
         else send_path();
      end
      steady = 1'b0;
      req_bus.valid <= 1'b0;

      // drain
      waited = 0;
      while (tracker.pending_segments.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);

      $display("Run covered %0d characters over %0d paths, %0d segments checked (%0d closing).",
               tracker.chars_taken, tracker.paths_started, tracker.segments_checked,
               tracker.closes_checked);
      if (tracker.close_out() == 0) begin
         $display("relative_path_segment_parser_tb passed");
      end else begin
         $display("relative_path_segment_parser_tb failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("relative_path_segment_parser_tb failed");
      $finish;
   end

endmodule

/* files.f */
design/rpsp_pkg.sv
design/rpsp_if.sv
design/relative_path_segment_parser.sv
dv/relative_path_segment_parser_tb.sv
